[design/stable_quadratic_root_solver_macros.svh]
// Assertion macros used by the checker of the root solver.
`ifndef STABLE_QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define STABLE_QUADRATIC_ROOT_SOLVER_MACROS_SVH

// Clocked implication, disabled while reset is asserted.
`define SQRS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A signal holds its value in the cycle after a condition.
`define SQRS_ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

[design/sqrs_pkg.sv]
`timescale 1ns / 1ps

package sqrs_pkg;

  // Fraction bits of the root format
  localparam int unsigned RootFrac = 16;

  // Root classification codes
  typedef enum logic [1:0] {
    ST_AZERO  = 2'd0,
    ST_TWO    = 2'd1,
    ST_DOUBLE = 2'd2,
    ST_NONE   = 2'd3
  } status_e;

endpackage

[design/sqrs_sqrt.sv]
`timescale 1ns / 1ps

// Pipelined integer square root, one root bit per stage, floor result.
module sqrs_sqrt #(
  parameter int unsigned IN_W = 34
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [IN_W-1:0]     d_i,
  output logic [IN_W/2-1:0]   root_o
);

  localparam int unsigned RtW = IN_W / 2;

  logic [IN_W-1:0] d_q    [RtW];
  logic [RtW+1:0]  rem_q  [RtW];
  logic [RtW-1:0]  root_q [RtW];

  for (genvar i = 0; i < RtW; i++) begin : g_stage
    logic [IN_W-1:0] din;
    logic [RtW+1:0]  rin;
    logic [RtW-1:0]  qin;
    logic [RtW+1:0]  rsh;
    logic [RtW+1:0]  trial;
    logic            ge;

    if (i == 0) begin : g_first
      assign din = d_i;
      assign rin = '0;
      assign qin = '0;
    end else begin : g_next
      assign din = d_q[i-1];
      assign rin = rem_q[i-1];
      assign qin = root_q[i-1];
    end

    // bring down the next bit pair and try 4*root+1
    assign rsh   = {rin[RtW-1:0], din[IN_W-1 -: 2]};
    assign trial = {qin, 2'b01};
    assign ge    = (rsh >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[i]    <= {din[IN_W-3:0], 2'b00};
        rem_q[i]  <= ge ? (rsh - trial) : rsh;
        root_q[i] <= {qin[RtW-2:0], ge};
      end
    end
  end

  assign root_o = root_q[RtW-1];

endmodule

[design/sqrs_div.sv]
`timescale 1ns / 1ps

// Pipelined restoring divider: (num << FRAC) / den, one quotient bit per stage.
module sqrs_div #(
  parameter int unsigned N_W  = 18,
  parameter int unsigned D_W  = 18,
  parameter int unsigned FRAC = 16
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [N_W-1:0]      num_i,
  input  logic [D_W-1:0]      den_i,
  output logic [N_W+FRAC-1:0] quo_o,
  output logic                dz_o
);

  localparam int unsigned QW = N_W + FRAC;

  logic [QW-1:0]  n_q   [QW];
  logic [D_W-1:0] rem_q [QW];
  logic [QW-1:0]  quo_q [QW];
  logic [D_W-1:0] den_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [QW-1:0]  nin;
    logic [D_W-1:0] rin;
    logic [QW-1:0]  qin;
    logic [D_W-1:0] dvi;
    logic [D_W:0]   rsh;
    logic [D_W:0]   sub;
    logic           ge;

    if (i == 0) begin : g_first
      assign nin = {num_i, {FRAC{1'b0}}};
      assign rin = '0;
      assign qin = '0;
      assign dvi = den_i;
    end else begin : g_next
      assign nin = n_q[i-1];
      assign rin = rem_q[i-1];
      assign qin = quo_q[i-1];
      assign dvi = den_q[i-1];
    end

    // shift in one dividend bit, subtract when it fits
    assign rsh = {rin, nin[QW-1]};
    assign ge  = (rsh >= {1'b0, dvi});
    assign sub = rsh - {1'b0, dvi};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[i]   <= {nin[QW-2:0], 1'b0};
        rem_q[i] <= ge ? sub[D_W-1:0] : rsh[D_W-1:0];
        quo_q[i] <= {qin[QW-2:0], ge};
        den_q[i] <= dvi;
      end
    end
  end

  assign quo_o = quo_q[QW-1];
  assign dz_o  = (den_q[QW-1] == '0);

endmodule

[design/stable_quadratic_root_solver.sv]
`timescale 1ns / 1ps

// Channel | Valid   | Stall   | Payload
// input   | valid_i | stall_o | coef_quad_i, coef_lin_i, coef_const_i
// output  | valid_o | stall_i | status_o, first_root_o, second_root_o, saturated_o
//
// One word enters per cycle while the output is not stalled; the pipeline depth is set
// by the one-bit-per-stage square root and the two parallel dividers.
// Reset clears all valid bits; payload registers are not reset.
// A stalled output word freezes the whole pipeline; nothing is lost or repeated.
module stable_quadratic_root_solver #(
  parameter int unsigned COEF_WIDTH = 16,
  parameter int unsigned ROOT_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic signed [COEF_WIDTH-1:0] coef_quad_i,
  input  logic signed [COEF_WIDTH-1:0] coef_lin_i,
  input  logic signed [COEF_WIDTH-1:0] coef_const_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic [1:0]                   status_o,
  output logic signed [ROOT_WIDTH-1:0] first_root_o,
  output logic signed [ROOT_WIDTH-1:0] second_root_o,
  output logic                         saturated_o
);

  localparam int unsigned W   = COEF_WIDTH;
  localparam int unsigned RW  = ROOT_WIDTH;
  localparam int unsigned DW  = 2 * W + 2;
  localparam int unsigned SW  = W + 1;
  localparam int unsigned TW  = W + 2;
  localparam int unsigned QW  = TW + sqrs_pkg::RootFrac;
  localparam int unsigned CW  = ((QW > RW) ? QW : RW) + 1;

  typedef struct packed {
    sqrs_pkg::status_e status;
    logic              bpos;
    logic              aneg;
    logic              cneg;
  } side_t;

  logic en;
  logic vout_q;

  assign en      = !(vout_q && stall_i);
  assign stall_o = vout_q && stall_i;

  // stage 1: input register
  logic                 v1_q;
  logic [W-1:0]         a1_q, b1_q, c1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q <= coef_quad_i;
      b1_q <= coef_lin_i;
      c1_q <= coef_const_i;
    end
  end

  // stage 2: magnitudes and products
  logic [W-1:0]   ma_d, mb_d, mc_d;
  logic           v2_q;
  logic [2*W-1:0] p2_q, mac2_q;
  logic           acpos2_q, azero2_q, bpos2_q, aneg2_q, cneg2_q;
  logic [W-1:0]   ma2_q, mb2_q, mc2_q;

  assign ma_d = a1_q[W-1] ? (~a1_q + 1'b1) : a1_q;
  assign mb_d = b1_q[W-1] ? (~b1_q + 1'b1) : b1_q;
  assign mc_d = c1_q[W-1] ? (~c1_q + 1'b1) : c1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_q     <= mb_d * mb_d;
      mac2_q   <= ma_d * mc_d;
      acpos2_q <= (a1_q != '0) && (c1_q != '0) && (a1_q[W-1] == c1_q[W-1]);
      azero2_q <= (a1_q == '0);
      bpos2_q  <= !b1_q[W-1] && (b1_q != '0);
      aneg2_q  <= a1_q[W-1];
      cneg2_q  <= c1_q[W-1];
      ma2_q    <= ma_d;
      mb2_q    <= mb_d;
      mc2_q    <= mc_d;
    end
  end

  // stage 3: discriminant and classification
  logic [DW-1:0] q4, pz, d_d;
  logic          dneg;
  side_t         side3_d;
  logic          v3_q;
  logic [DW-1:0] d3_q;
  side_t         side3_q;
  logic [W-1:0]  ma3_q, mb3_q, mc3_q;

  assign q4   = {mac2_q, 2'b00};
  assign pz   = {2'b00, p2_q};
  assign dneg = acpos2_q && (q4 > pz);
  assign d_d  = acpos2_q ? (pz - q4) : (pz + q4);

  always_comb begin
    side3_d.bpos = bpos2_q;
    side3_d.aneg = aneg2_q;
    side3_d.cneg = cneg2_q;
    if (azero2_q) begin
      side3_d.status = sqrs_pkg::ST_AZERO;
    end else if (dneg) begin
      side3_d.status = sqrs_pkg::ST_NONE;
    end else if (d_d == '0) begin
      side3_d.status = sqrs_pkg::ST_DOUBLE;
    end else begin
      side3_d.status = sqrs_pkg::ST_TWO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d3_q    <= d_d;
      side3_q <= side3_d;
      ma3_q   <= ma2_q;
      mb3_q   <= mb2_q;
      mc3_q   <= mc2_q;
    end
  end

  // square root pipeline
  logic [SW-1:0] root;

  sqrs_sqrt #(
    .IN_W(DW)
  ) u_sqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (d3_q),
    .root_o(root)
  );

  // side data follows the root pipeline
  logic [SW-1:0] vs_q;
  side_t         ss_q [SW];
  logic [W-1:0]  mas_q [SW];
  logic [W-1:0]  mbs_q [SW];
  logic [W-1:0]  mcs_q [SW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= '0;
    end else if (en) begin
      vs_q <= {vs_q[SW-2:0], v3_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = SW - 1; k > 0; k--) begin
        ss_q[k]  <= ss_q[k-1];
        mas_q[k] <= mas_q[k-1];
        mbs_q[k] <= mbs_q[k-1];
        mcs_q[k] <= mcs_q[k-1];
      end
      ss_q[0]  <= side3_q;
      mas_q[0] <= ma3_q;
      mbs_q[0] <= mb3_q;
      mcs_q[0] <= mc3_q;
    end
  end

  // stage 4: stable numerator |b| + s and the divider operands
  logic          v4_q;
  logic [TW-1:0] mt4_q, dena4_q, numb4_q;
  side_t         side4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= vs_q[SW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mt4_q   <= {2'b00, mbs_q[SW-1]} + {1'b0, root};
      dena4_q <= {1'b0, mas_q[SW-1], 1'b0};
      numb4_q <= {1'b0, mcs_q[SW-1], 1'b0};
      side4_q <= ss_q[SW-1];
    end
  end

  // quotient A = t / 2a, quotient B = 2c / t
  logic [QW-1:0] qa, qb;
  logic          dza, dzb;

  sqrs_div #(
    .N_W (TW),
    .D_W (TW),
    .FRAC(sqrs_pkg::RootFrac)
  ) u_div_a (
    .clk_i(clk_i),
    .en_i (en),
    .num_i(mt4_q),
    .den_i(dena4_q),
    .quo_o(qa),
    .dz_o (dza)
  );

  sqrs_div #(
    .N_W (TW),
    .D_W (TW),
    .FRAC(sqrs_pkg::RootFrac)
  ) u_div_b (
    .clk_i(clk_i),
    .en_i (en),
    .num_i(numb4_q),
    .den_i(mt4_q),
    .quo_o(qb),
    .dz_o (dzb)
  );

  // side data follows the dividers
  logic [QW-1:0] vq_q;
  side_t         sq_q [QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq_q <= '0;
    end else if (en) begin
      vq_q <= {vq_q[QW-2:0], v4_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = QW - 1; k > 0; k--) begin
        sq_q[k] <= sq_q[k-1];
      end
      sq_q[0] <= side4_q;
    end
  end

  // sign, zero divisor and clamp; returns {sat, value}
  function automatic logic [RW:0] fix_q(logic [QW-1:0] q, logic neg, logic dz);
    logic [CW-1:0] qe;
    logic [CW-1:0] lim;
    logic [CW-1:0] limm1;
    logic [CW-1:0] nq;
    logic [RW-1:0] r;
    logic          s;
    qe    = CW'(q);
    lim   = CW'(1) << (RW - 1);
    limm1 = lim - 1'b1;
    nq    = ~qe + 1'b1;
    s     = 1'b0;
    if (dz) begin
      r = '0;
    end else if (neg) begin
      if (qe > lim) begin
        r = lim[RW-1:0];
        s = 1'b1;
      end else begin
        r = nq[RW-1:0];
      end
    end else begin
      if (qe > limm1) begin
        r = limm1[RW-1:0];
        s = 1'b1;
      end else begin
        r = qe[RW-1:0];
      end
    end
    return {s, r};
  endfunction

  // final stage: order roots by the branch and mask by status
  side_t         sf;
  logic [RW:0]   fa, fb;
  logic [RW-1:0] r1_d, r2_d;
  logic          sat_d;

  assign sf = sq_q[QW-1];
  assign fa = fix_q(qa, sf.bpos ^ sf.aneg, dza);
  assign fb = fix_q(qb, sf.bpos ^ sf.cneg, dzb);

  always_comb begin
    case (sf.status)
      sqrs_pkg::ST_TWO: begin
        r1_d  = sf.bpos ? fb[RW-1:0] : fa[RW-1:0];
        r2_d  = sf.bpos ? fa[RW-1:0] : fb[RW-1:0];
        sat_d = fa[RW] | fb[RW];
      end
      sqrs_pkg::ST_DOUBLE: begin
        r1_d  = sf.bpos ? fb[RW-1:0] : fa[RW-1:0];
        r2_d  = r1_d;
        sat_d = sf.bpos ? fb[RW] : fa[RW];
      end
      default: begin
        r1_d  = '0;
        r2_d  = '0;
        sat_d = 1'b0;
      end
    endcase
  end

  // output register
  logic [1:0]    status_q;
  logic [RW-1:0] r1_q, r2_q;
  logic          sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else if (en) begin
      vout_q <= vq_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      status_q <= sf.status;
      r1_q     <= r1_d;
      r2_q     <= r2_d;
      sat_q    <= sat_d;
    end
  end

  assign valid_o       = vout_q;
  assign status_o      = status_q;
  assign first_root_o  = r1_q;
  assign second_root_o = r2_q;
  assign saturated_o   = sat_q;

endmodule

[design/sqrs_checker.sv]
`timescale 1ns / 1ps
`include "stable_quadratic_root_solver_macros.svh"

// Port-level checks on the root solver output.
module sqrs_checker #(
  parameter int unsigned COEF_WIDTH = 16,
  parameter int unsigned ROOT_WIDTH = 32
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         valid_i,
  input logic                         stall_o,
  input logic signed [COEF_WIDTH-1:0] coef_quad_i,
  input logic signed [COEF_WIDTH-1:0] coef_lin_i,
  input logic signed [COEF_WIDTH-1:0] coef_const_i,
  input logic                         valid_o,
  input logic                         stall_i,
  input logic [1:0]                   status_o,
  input logic signed [ROOT_WIDTH-1:0] first_root_o,
  input logic signed [ROOT_WIDTH-1:0] second_root_o,
  input logic                         saturated_o
);

  // a stalled word stays put
  `SQRS_ASSERT_HOLD(a_hold, clk_i, rst_ni, valid_o && stall_i, {valid_o, status_o, first_root_o, second_root_o, saturated_o}, "output word changed under stall")

  // a stalled input word is held by the sender
  `SQRS_ASSERT_HOLD(a_in_hold, clk_i, rst_ni, valid_i && stall_o, {valid_i, coef_quad_i, coef_lin_i, coef_const_i}, "input word changed under stall")

  // no real roots or a zero leading term reports all zero
  `SQRS_ASSERT(a_noroot_zero, clk_i, rst_ni, (valid_o && (status_o == sqrs_pkg::ST_AZERO || status_o == sqrs_pkg::ST_NONE)) |-> (first_root_o == '0 && second_root_o == '0 && !saturated_o), "roots not cleared for status without roots")

  // a double root repeats itself
  `SQRS_ASSERT(a_double_same, clk_i, rst_ni, (valid_o && status_o == sqrs_pkg::ST_DOUBLE) |-> (first_root_o == second_root_o), "double root differs")

  // the input side only stalls while the output is stalled
  `SQRS_ASSERT(a_stall_path, clk_i, rst_ni, stall_o |-> (valid_o && stall_i), "input stalled without output stall")

endmodule

bind stable_quadratic_root_solver sqrs_checker #(
  .COEF_WIDTH(COEF_WIDTH),
  .ROOT_WIDTH(ROOT_WIDTH)
) u_sqrs_checker (.*);

[dv/tb_stable_quadratic_root_solver.sv]
`timescale 1ns / 1ps

module tb_stable_quadratic_root_solver;

  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
  } coef_t;

  typedef struct {
    sqrs_pkg::status_e  status;
    logic signed [31:0] root1;
    logic signed [31:0] root2;
    logic               sat;
  } roots_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               valid_i = 1'b0;
  logic               stall_o;
  logic signed [15:0] coef_quad_i = '0;
  logic signed [15:0] coef_lin_i = '0;
  logic signed [15:0] coef_const_i = '0;
  logic               valid_o;
  logic               stall_i = 1'b0;
  logic [1:0]         status_o;
  logic signed [31:0] first_root_o;
  logic signed [31:0] second_root_o;
  logic               saturated_o;

  coef_t  coef_q[$];
  roots_t roots_q[$];
  int     errors = 0;
  int     cyc = 0;

  stable_quadratic_root_solver dut (.*);

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cyc, what);
    errors++;
  endtask

  // floor of the square root of a nonnegative value
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned bitv;
    r = 0;
    bitv = 64'd1 << 40;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // Q16.16 quotient, truncated toward zero, clamped to 32 bits
  function automatic logic signed [31:0] q16_div(input longint num, input longint den,
                                                 inout logic sat);
    longint unsigned mn, md, q;
    logic neg;
    if (den == 0) return '0;
    neg = (num < 0) != (den < 0);
    mn = (num < 0) ? -num : num;
    md = (den < 0) ? -den : den;
    q = (mn << 16) / md;
    if (neg) begin
      if (q > 64'h8000_0000) begin
        q = 64'h8000_0000;
        sat = 1'b1;
      end
      q = -q;
      return q[31:0];
    end
    if (q > 64'h7FFF_FFFF) begin
      q = 64'h7FFF_FFFF;
      sat = 1'b1;
    end
    return q[31:0];
  endfunction

  function automatic roots_t solve_roots(input coef_t w);
    roots_t r;
    longint a, b, c, d, s, t;
    a = w.a;
    b = w.b;
    c = w.c;
    d = b * b - 4 * a * c;
    r.root1 = '0;
    r.root2 = '0;
    r.sat = 1'b0;
    if (a == 0) r.status = sqrs_pkg::ST_AZERO;
    else if (d > 0) r.status = sqrs_pkg::ST_TWO;
    else if (d == 0) r.status = sqrs_pkg::ST_DOUBLE;
    else r.status = sqrs_pkg::ST_NONE;
    if (r.status == sqrs_pkg::ST_TWO || r.status == sqrs_pkg::ST_DOUBLE) begin
      s = floor_sqrt(d);
      t = (b > 0) ? -b - s : -b + s;
      if (b > 0) begin
        r.root1 = q16_div(2 * c, t, r.sat);
        r.root2 = q16_div(t, 2 * a, r.sat);
      end else begin
        r.root1 = q16_div(t, 2 * a, r.sat);
        r.root2 = q16_div(2 * c, t, r.sat);
      end
      if (r.status == sqrs_pkg::ST_DOUBLE) begin
        r.sat = 1'b0;
        r.root1 = (b > 0) ? q16_div(2 * c, t, r.sat) : q16_div(t, 2 * a, r.sat);
        r.root2 = r.root1;
      end
    end
    return r;
  endfunction

  // quiet window: no idling on either side
  wire quiet = (cyc >= 250) && (cyc < 420);

  // driver; the head of the queue is the word on the bus or the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_i <= 1'b0;
    end else begin
      if (valid_i && !stall_o) begin
        roots_q.push_back(solve_roots('{coef_quad_i, coef_lin_i, coef_const_i}));
        void'(coef_q.pop_front());
      end
      if (!valid_i || !stall_o) begin
        if (coef_q.size() > 0 && (quiet || $urandom_range(99) >= 17)) begin
          coef_t w;
          w = coef_q[0];
          valid_i      <= 1'b1;
          coef_quad_i  <= w.a;
          coef_lin_i   <= w.b;
          coef_const_i <= w.c;
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (rst_ni) begin
      stall_i <= !quiet && ($urandom_range(99) < 17);
      if (valid_o && !stall_i) begin
        if (roots_q.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          roots_t e;
          e = roots_q.pop_front();
          if (status_o !== e.status)
            report($sformatf("status %0d, expected %0d", status_o, e.status));
          if (first_root_o !== e.root1)
            report($sformatf("first root %h, expected %h", first_root_o, e.root1));
          if (second_root_o !== e.root2)
            report($sformatf("second root %h, expected %h", second_root_o, e.root2));
          if (saturated_o !== e.sat)
            report($sformatf("saturated %b, expected %b", saturated_o, e.sat));
        end
      end
    end
  end

  task automatic add(input int a, input int b, input int c);
    coef_t w;
    w.a = 16'(a);
    w.b = 16'(b);
    w.c = 16'(c);
    coef_q.push_back(w);
  endtask

  // stimulus
  initial begin
    int m, n;
    // directed: zero a, extremes, both branches, double root, no roots,
    // zero denominator, saturation
    add(0, 256, 256);
    add(0, 0, 0);
    add(-32768, -32768, -32768);
    add(32767, 32767, 32767);
    add(-32768, 32767, 32767);
    add(32767, -32768, 32767);
    add(256, 512, 256);
    add(256, -512, 256);
    add(256, 0, 256);
    add(256, 0, 0);
    add(256, 0, -256);
    add(256, 768, 512);
    add(256, -768, 512);
    add(1, -32768, 1);
    add(1, 32767, 1);
    add(-1, 32767, 1);
    add(1, 0, -32768);
    add(-32768, 0, 32767);
    add(32767, 1, -1);
    add(16'hFFFF, 16'h7FFF, 16'h8000);
    for (int i = 0; i < 550; i++) begin
      case ($urandom_range(3))
        0: begin
          m = $urandom_range(64) - 32;
          if (m == 0) m = 1;
          n = $urandom_range(16) - 8;
          add(m * 8, 2 * m * 8 * n, m * 8 * n * n);
        end
        1: add($urandom_range(15) - 7, $urandom, $urandom);
        default: add($urandom, $urandom, $urandom);
      endcase
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (coef_q.size() == 0 && roots_q.size() == 0);
    repeat (120) @(posedge clk_i);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
